FILE: rtl/icprc_pkg.sv
`default_nettype none

package icprc_pkg;

  // Default size of the receive buffer, in bytes.
  localparam int unsigned MAX_PACKET_BYTES_DEF = 1024;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned HLEN_W    = 6;
  localparam int unsigned LENGTH_W  = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Packet layout and limits.
  localparam int unsigned MIN_PACKET   = 28;
  localparam int unsigned MIN_HEADER   = 20;
  localparam int unsigned ICMP_HDR_LEN = 8;
  localparam int unsigned PROTO_OFFSET = 9;

  localparam logic [BYTE_W-1:0] PROTO_UDP          = 8'd17;
  localparam logic [BYTE_W-1:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [BYTE_W-1:0] CODE_IN_TRANSIT    = 8'd0;
  localparam logic [BYTE_W-1:0] TYPE_UNREACHABLE   = 8'd3;

  localparam logic [PORT_W-1:0] SRC_PORT_RESET = 16'd32768;
  localparam logic [PORT_W-1:0] DST_PORT_RESET = 16'd32968;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_PORT = 2'd0,
    CFG_DST_PORT = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_IGNORED       = 2'd0,
    VERDICT_TIME_EXCEEDED = 2'd1,
    VERDICT_UNREACHABLE   = 2'd2,
    VERDICT_MALFORMED     = 2'd3
  } verdict_t;

endpackage

`default_nettype wire

FILE: rtl/icprc_in_if.sv
`default_nettype none

interface icprc_in_if;
  import icprc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packet_byte;
  logic              is_last;

  modport source (output valid, output packet_byte, output is_last, input ready);
  modport sink   (input valid, input packet_byte, input is_last, output ready);

endinterface

`default_nettype wire

FILE: rtl/icprc_out_if.sv
`default_nettype none

interface icprc_out_if;
  import icprc_pkg::*;

  logic                valid;
  logic                ready;
  verdict_t            verdict;
  logic [LENGTH_W-1:0] packet_length;

  modport source (output valid, output verdict, output packet_length, input ready);
  modport sink   (input valid, input verdict, input packet_length, output ready);

endinterface

`default_nettype wire

FILE: rtl/icmp_probe_reply_classifier.sv
// Classifies a received IPv4 packet as a reply to a UDP probe.
// The packet arrives on in_ch one byte per transfer, in order, with is_last set
// on its final byte. Every byte but the last produces nothing; the last byte
// produces exactly one transfer on out_ch carrying the verdict (ignored, time
// exceeded in transit, destination unreachable or malformed) and the number
// of bytes counted, which saturates at MAX_PACKET_BYTES.
// The probe ports are set through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while the block is idle; the block itself does not
// enforce this. Writes to an unknown index are dropped. An accepted byte is
// held in the input register and processed from there, and the result of a
// packet is held in the result register once its last byte leaves the input
// register. One byte is taken in every cycle unless a final byte is waiting
// in the single input register that feeds the capture logic.
// When the receiver stalls, the result register holds its transfer; bytes
// that do not end a packet keep flowing, and only a final byte waits in the
// input register until the result register is free.
// A synchronous reset empties both registers, clears the packet state and
// restores the probe ports to their defaults.
`default_nettype none

module icmp_probe_reply_classifier #(
  parameter int unsigned MAX_PACKET_BYTES = icprc_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  icprc_in_if.sink                                in_ch,
  icprc_out_if.source                             out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [icprc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [icprc_pkg::PORT_W-1:0]       cfg_wdata
);
  import icprc_pkg::*;

  // Byte counter wide enough to hold the buffer size itself.
  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  // Header offsets reach 131, so compares need at least 8 bits.
  localparam int unsigned CMP_W = (POS_W > 8) ? POS_W : 8;

  // Probe port registers.
  logic [PORT_W-1:0] src_port_r, src_port_nxt;
  logic [PORT_W-1:0] dst_port_r, dst_port_nxt;

  // Input register.
  logic              s0_valid_r, s0_valid_nxt;
  logic [BYTE_W-1:0] s0_byte_r;
  logic              s0_last_r;
  logic              s0_move;
  logic              s0_fire;
  logic              in_fire;

  // Per-packet state.
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [HLEN_W-1:0] outer_r, outer_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] code_r, code_nxt;
  logic [HLEN_W-1:0] inner_len_r, inner_len_nxt;
  logic [BYTE_W-1:0] proto_r, proto_nxt;
  logic [PORT_W-1:0] seen_src_r, seen_src_nxt;
  logic [PORT_W-1:0] seen_dst_r, seen_dst_nxt;
  logic              ports_done_r, ports_done_nxt;

  // State after capturing the current byte, before any end-of-packet clear.
  logic [POS_W-1:0]  cap_pos;
  logic [HLEN_W-1:0] cap_outer;
  logic [BYTE_W-1:0] cap_type;
  logic [BYTE_W-1:0] cap_code;
  logic [HLEN_W-1:0] cap_inner_len;
  logic [BYTE_W-1:0] cap_proto;
  logic [PORT_W-1:0] cap_src;
  logic [PORT_W-1:0] cap_dst;
  logic              cap_ports_done;

  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  outer_x;
  logic [CMP_W-1:0]  inner_off;
  logic [CMP_W-1:0]  ports_off;
  logic              in_range;
  verdict_t          verdict;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  verdict_t            verdict_r, verdict_nxt;
  logic [LENGTH_W-1:0] length_r, length_nxt;

  // Configuration writes.
  always_comb begin
    src_port_nxt = src_port_r;
    dst_port_nxt = dst_port_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_PORT: src_port_nxt = cfg_wdata;
        CFG_DST_PORT: dst_port_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // A final byte may only leave the input register when the result register
  // can take its transfer; every other byte moves on at once.
  assign s0_move     = !s0_last_r || !out_valid_r || out_ch.ready;
  assign s0_fire     = s0_valid_r && s0_move;
  assign in_ch.ready = !s0_valid_r || s0_move;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_fire) begin
      s0_valid_nxt = 1'b1;
    end else if (s0_fire) begin
      s0_valid_nxt = 1'b0;
    end
  end

  // Offsets within the packet. The embedded header and port offsets use the
  // lengths held before this byte, so a length captured now takes effect
  // from the next byte on.
  assign pos_x     = CMP_W'(pos_r);
  assign inner_off = CMP_W'(outer_r) + CMP_W'(ICMP_HDR_LEN);
  assign ports_off = inner_off + CMP_W'(inner_len_r);
  assign in_range  = pos_r < POS_W'(MAX_PACKET_BYTES);
  assign outer_x   = CMP_W'(cap_outer);

  always_comb begin
    cap_pos        = pos_r;
    cap_outer      = outer_r;
    cap_type       = type_r;
    cap_code       = code_r;
    cap_inner_len  = inner_len_r;
    cap_proto      = proto_r;
    cap_src        = seen_src_r;
    cap_dst        = seen_dst_r;
    cap_ports_done = ports_done_r;
    if (in_range) begin
      cap_pos = pos_r + POS_W'(1);
      if (pos_r == '0) begin
        cap_outer = {s0_byte_r[3:0], 2'b00};
      end
      // The type compare sees the header length just taken from the first
      // byte, so an empty outer header places the type at the first byte.
      if (pos_x == outer_x) begin
        cap_type = s0_byte_r;
      end
      if (pos_x == outer_x + CMP_W'(1)) begin
        cap_code = s0_byte_r;
      end
      if (pos_x == inner_off + CMP_W'(PROTO_OFFSET)) begin
        cap_proto = s0_byte_r;
      end
      if (pos_x == ports_off) begin
        cap_src[15:8] = s0_byte_r;
      end
      if (pos_x == ports_off + CMP_W'(1)) begin
        cap_src[7:0] = s0_byte_r;
      end
      if (pos_x == ports_off + CMP_W'(2)) begin
        cap_dst[15:8] = s0_byte_r;
      end
      if (pos_x == ports_off + CMP_W'(3)) begin
        cap_dst[7:0]   = s0_byte_r;
        cap_ports_done = 1'b1;
      end
      if (pos_x == inner_off) begin
        cap_inner_len = {s0_byte_r[3:0], 2'b00};
      end
    end
  end

  // Classification of a finished packet. Malformed is checked first; a
  // short embedded header or a packet that ends before both ports is
  // ignored, as is anything that does not match the probe.
  always_comb begin
    if (CMP_W'(cap_pos) < CMP_W'(MIN_PACKET) || cap_outer < HLEN_W'(MIN_HEADER)) begin
      verdict = VERDICT_MALFORMED;
    end else if (cap_inner_len < HLEN_W'(MIN_HEADER) || !cap_ports_done) begin
      verdict = VERDICT_IGNORED;
    end else if (cap_proto != PROTO_UDP || cap_src != src_port_r ||
                 cap_dst != dst_port_r) begin
      verdict = VERDICT_IGNORED;
    end else if (cap_type == TYPE_TIME_EXCEEDED && cap_code == CODE_IN_TRANSIT) begin
      verdict = VERDICT_TIME_EXCEEDED;
    end else if (cap_type == TYPE_UNREACHABLE) begin
      verdict = VERDICT_UNREACHABLE;
    end else begin
      verdict = VERDICT_IGNORED;
    end
  end

  // Packet state update; everything is cleared after the final byte.
  always_comb begin
    pos_nxt        = pos_r;
    outer_nxt      = outer_r;
    type_nxt       = type_r;
    code_nxt       = code_r;
    inner_len_nxt  = inner_len_r;
    proto_nxt      = proto_r;
    seen_src_nxt   = seen_src_r;
    seen_dst_nxt   = seen_dst_r;
    ports_done_nxt = ports_done_r;
    if (s0_fire) begin
      if (s0_last_r) begin
        pos_nxt        = '0;
        outer_nxt      = '0;
        type_nxt       = '0;
        code_nxt       = '0;
        inner_len_nxt  = '0;
        proto_nxt      = '0;
        seen_src_nxt   = '0;
        seen_dst_nxt   = '0;
        ports_done_nxt = 1'b0;
      end else begin
        pos_nxt        = cap_pos;
        outer_nxt      = cap_outer;
        type_nxt       = cap_type;
        code_nxt       = cap_code;
        inner_len_nxt  = cap_inner_len;
        proto_nxt      = cap_proto;
        seen_src_nxt   = cap_src;
        seen_dst_nxt   = cap_dst;
        ports_done_nxt = cap_ports_done;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    verdict_nxt   = verdict_r;
    length_nxt    = length_r;
    if (s0_fire && s0_last_r) begin
      out_valid_nxt = 1'b1;
      verdict_nxt   = verdict;
      length_nxt    = LENGTH_W'(cap_pos);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.verdict       = verdict_r;
  assign out_ch.packet_length = length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_port_r   <= SRC_PORT_RESET;
      dst_port_r   <= DST_PORT_RESET;
      s0_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pos_r        <= '0;
      outer_r      <= '0;
      type_r       <= '0;
      code_r       <= '0;
      inner_len_r  <= '0;
      proto_r      <= '0;
      seen_src_r   <= '0;
      seen_dst_r   <= '0;
      ports_done_r <= 1'b0;
    end else begin
      src_port_r   <= src_port_nxt;
      dst_port_r   <= dst_port_nxt;
      s0_valid_r   <= s0_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pos_r        <= pos_nxt;
      outer_r      <= outer_nxt;
      type_r       <= type_nxt;
      code_r       <= code_nxt;
      inner_len_r  <= inner_len_nxt;
      proto_r      <= proto_nxt;
      seen_src_r   <= seen_src_nxt;
      seen_dst_r   <= seen_dst_nxt;
      ports_done_r <= ports_done_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_byte_r <= in_ch.packet_byte;
      s0_last_r <= in_ch.is_last;
    end
    verdict_r <= verdict_nxt;
    length_r  <= length_nxt;
  end

endmodule

`default_nettype wire
